[design/butterworth_freq_domain_filter_core_defines.svh]
// Assertion macros used by the checker file.
`ifndef BUTTERWORTH_FREQ_DOMAIN_FILTER_CORE_DEFINES_SVH
`define BUTTERWORTH_FREQ_DOMAIN_FILTER_CORE_DEFINES_SVH

// Same-cycle implication, off while reset is held.
`define BWFD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off while reset is held.
`define BWFD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Same-cycle implication that is also checked around reset.
`define BWFD_ASSERT_RST(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |-> (cons)) \
    else $error(msg);

`endif

[design/bwfd_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package bwfd_pkg;
  localparam int SAMPLE_WIDTH = 16;
  localparam int BIN_W        = 12;
  localparam int RATIO_W      = 24;
  localparam int ORDER_W      = 2;
  localparam int CFG_INDEX_W  = 2;
  localparam int CFG_DATA_W   = 24;
  localparam int IN_TDATA_W   = 48;
  localparam int OUT_TDATA_W  = 32;

  localparam int X_W    = SAMPLE_WIDTH + 1;
  localparam int PROD_W = BIN_W + RATIO_W;
  localparam int WW_W   = 32;
  localparam int SW_W   = 25;
  localparam int RE_W   = 34;
  localparam int MAG_W  = 30;
  localparam int RES_W  = MAG_W + 1;
  localparam int XP_W   = 48;
  localparam int RR_W   = 60;
  localparam int II_W   = 50;
  localparam int DEN_W  = 61;
  localparam int NUM_W  = 62;
  localparam int MAGN_W = 47;
  localparam int Q_BITS = 18;
  localparam int DSH_W  = DEN_W + Q_BITS - 1;
  localparam int N_CELLS = Q_BITS;

  localparam logic [RATIO_W-1:0] RATIO_MAX = '1;
  localparam logic [16:0] SQRT2_Q16 = 17'd92681;
  localparam logic signed [RE_W-1:0] ONE_Q16 = 34'sd65536;
  localparam logic signed [X_W-1:0] X_ONE = {2'b01, {(SAMPLE_WIDTH-1){1'b0}}};

  localparam logic [CFG_INDEX_W-1:0] REG_ORDER = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_RATIO = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_RESP  = 2'd2;

  localparam logic [ORDER_W-1:0] ORDER_NONE = 2'd0;
  localparam logic [ORDER_W-1:0] ORDER_ONE  = 2'd1;
  localparam logic [ORDER_W-1:0] ORDER_TWO  = 2'd2;

  typedef struct packed {
    logic [ORDER_W-1:0] order;
    logic [RATIO_W-1:0] ratio;
    logic               resp;
  } cfg_t;

  typedef struct packed {
    logic [DSH_W-1:0]  dsh;
    logic [NUM_W-1:0]  rem_re;
    logic [NUM_W-1:0]  rem_im;
    logic [Q_BITS-1:0] q_re;
    logic [Q_BITS-1:0] q_im;
    logic              neg_re;
    logic              neg_im;
  } div_item_t;
endpackage
`default_nettype wire

[design/bwfd_front.sv]
`timescale 1ns / 1ps
`default_nettype none
module bwfd_front (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  bwfd_pkg::cfg_t                          cfg,
  input  logic                                    s_valid,
  output logic                                    s_ready,
  input  logic [bwfd_pkg::BIN_W-1:0]              bin_index,
  input  logic signed [bwfd_pkg::SAMPLE_WIDTH-1:0] in_re,
  input  logic signed [bwfd_pkg::SAMPLE_WIDTH-1:0] in_im,
  output logic                                    m_valid,
  input  logic                                    m_ready,
  output bwfd_pkg::div_item_t                     m_item
);
  import bwfd_pkg::*;

  localparam int N_STG = 6;

  logic [N_STG-1:0] vld_r, vld_nxt, vld_in;
  logic [N_STG:0]   en;

  logic [PROD_W-1:0]       prod_r, prod_nxt;
  logic signed [X_W-1:0]   xr1_r, xi1_r, xr1_nxt, xi1_nxt;

  logic [RATIO_W-1:0]      w;
  logic [2*RATIO_W-1:0]    ww_full;
  logic [RATIO_W+16:0]     sw_full;
  logic [RATIO_W-1:0]      w2_r;
  logic [WW_W-1:0]         ww2_r;
  logic [SW_W-1:0]         sw2_r;
  logic signed [X_W-1:0]   xr2_r, xi2_r;

  logic signed [RE_W-1:0]  re;
  logic [SW_W-1:0]         im;
  logic [RE_W-1:0]         re_abs;
  logic [RE_W-2:0]         remag, mx;
  logic [1:0]              sh3_nxt;
  logic [RE_W-2:0]         remag_sh;
  logic [MAG_W-1:0]        mag3;
  logic signed [RES_W-1:0] re3_nxt, re3_r;
  logic [SW_W-1:0]         im3_nxt, im3_r;
  logic [1:0]              sh3_r;
  logic signed [X_W-1:0]   xr3_r, xi3_r;

  logic signed [2*RES_W-1:0] rr_full;
  logic signed [SW_W:0]      im_s;
  logic [RR_W-1:0]           rr4_r;
  logic [II_W-1:0]           ii4_r;
  logic signed [XP_W-1:0]    a4_nxt, b4_nxt, c4_nxt, d4_nxt;
  logic signed [XP_W-1:0]    a4_r, b4_r, c4_r, d4_r;
  logic [1:0]                sh4_r;

  logic [DEN_W-1:0]          den5_r;
  logic signed [XP_W-1:0]    nr5_r, ni5_r;
  logic [1:0]                sh5_r;

  logic [XP_W-1:0]           abs_re, abs_im;
  logic [NUM_W-1:0]          n_re, n_im;
  div_item_t                 item6_nxt, item6_r;

  always_comb begin
    en[N_STG] = m_ready;
    for (int i = N_STG - 1; i >= 0; i--) begin
      en[i] = !vld_r[i] || en[i+1];
    end
    vld_in = {vld_r[N_STG-2:0], s_valid};
    for (int i = 0; i < N_STG; i++) begin
      vld_nxt[i] = en[i] ? vld_in[i] : vld_r[i];
    end
  end

  assign s_ready = en[0];
  assign m_valid = vld_r[N_STG-1];
  assign m_item  = item6_r;

  // Stage 1: bin times ratio, input selection.
  always_comb begin
    prod_nxt = PROD_W'(bin_index) * PROD_W'(cfg.ratio);
    xr1_nxt  = cfg.resp ? X_ONE : {in_re[SAMPLE_WIDTH-1], in_re};
    xi1_nxt  = cfg.resp ? '0 : {in_im[SAMPLE_WIDTH-1], in_im};
  end

  // Stage 2: saturate w, square and scale.
  always_comb begin
    w       = (prod_r > PROD_W'(RATIO_MAX)) ? RATIO_MAX : prod_r[RATIO_W-1:0];
    ww_full = (2*RATIO_W)'(w) * (2*RATIO_W)'(w);
    sw_full = (RATIO_W+17)'(w) * (RATIO_W+17)'(SQRT2_Q16);
  end

  // Stage 3: denominator parts and normalization.
  always_comb begin
    case (cfg.order)
      ORDER_NONE: begin
        re = ONE_Q16;
        im = '0;
      end
      ORDER_ONE: begin
        re = ONE_Q16;
        im = {1'b0, w2_r};
      end
      default: begin
        re = ONE_Q16 - $signed({2'b00, ww2_r});
        im = sw2_r;
      end
    endcase
    re_abs = re[RE_W-1] ? RE_W'(-re) : RE_W'(re);
    remag  = re_abs[RE_W-2:0];
    mx     = (remag > (RE_W-1)'(im)) ? remag : (RE_W-1)'(im);
    if (mx[RE_W-2:MAG_W+1] != '0) begin
      sh3_nxt = 2'd2;
    end else if (mx[MAG_W]) begin
      sh3_nxt = 2'd1;
    end else begin
      sh3_nxt = 2'd0;
    end
    remag_sh = remag >> sh3_nxt;
    mag3     = remag_sh[MAG_W-1:0];
    re3_nxt  = re[RE_W-1] ? -$signed({1'b0, mag3}) : $signed({1'b0, mag3});
    im3_nxt  = im >> sh3_nxt;
  end

  // Stage 4: cross products and squares of the denominator parts.
  always_comb begin
    im_s    = $signed({1'b0, im3_r});
    rr_full = (2*RES_W)'(re3_r) * (2*RES_W)'(re3_r);
    a4_nxt  = XP_W'(xr3_r) * XP_W'(re3_r);
    b4_nxt  = XP_W'(xi3_r) * XP_W'(im_s);
    c4_nxt  = XP_W'(xi3_r) * XP_W'(re3_r);
    d4_nxt  = XP_W'(xr3_r) * XP_W'(im_s);
  end

  // Stage 6: magnitudes, scaling and divider setup.
  always_comb begin
    abs_re = nr5_r[XP_W-1] ? XP_W'(-nr5_r) : XP_W'(nr5_r);
    abs_im = ni5_r[XP_W-1] ? XP_W'(-ni5_r) : XP_W'(ni5_r);
    case (sh5_r)
      2'd0: begin
        n_re = NUM_W'(abs_re[MAGN_W-1:0]) << 16;
        n_im = NUM_W'(abs_im[MAGN_W-1:0]) << 16;
      end
      2'd1: begin
        n_re = NUM_W'(abs_re[MAGN_W-1:0]) << 15;
        n_im = NUM_W'(abs_im[MAGN_W-1:0]) << 15;
      end
      default: begin
        n_re = NUM_W'(abs_re[MAGN_W-1:0]) << 14;
        n_im = NUM_W'(abs_im[MAGN_W-1:0]) << 14;
      end
    endcase
    item6_nxt.dsh    = {den5_r, {(Q_BITS-1){1'b0}}};
    item6_nxt.rem_re = n_re;
    item6_nxt.rem_im = n_im;
    item6_nxt.q_re   = '0;
    item6_nxt.q_im   = '0;
    item6_nxt.neg_re = nr5_r[XP_W-1];
    item6_nxt.neg_im = ni5_r[XP_W-1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      prod_r <= prod_nxt;
      xr1_r  <= xr1_nxt;
      xi1_r  <= xi1_nxt;
    end
    if (en[1]) begin
      w2_r  <= w;
      ww2_r <= ww_full[2*RATIO_W-1:16];
      sw2_r <= sw_full[RATIO_W+16:16];
      xr2_r <= xr1_r;
      xi2_r <= xi1_r;
    end
    if (en[2]) begin
      re3_r <= re3_nxt;
      im3_r <= im3_nxt;
      sh3_r <= sh3_nxt;
      xr3_r <= xr2_r;
      xi3_r <= xi2_r;
    end
    if (en[3]) begin
      rr4_r <= rr_full[RR_W-1:0];
      ii4_r <= II_W'(im3_r) * II_W'(im3_r);
      a4_r  <= a4_nxt;
      b4_r  <= b4_nxt;
      c4_r  <= c4_nxt;
      d4_r  <= d4_nxt;
      sh4_r <= sh3_r;
    end
    if (en[4]) begin
      den5_r <= DEN_W'(rr4_r) + DEN_W'(ii4_r);
      nr5_r  <= a4_r + b4_r;
      ni5_r  <= c4_r - d4_r;
      sh5_r  <= sh4_r;
    end
    if (en[5]) begin
      item6_r <= item6_nxt;
    end
  end
endmodule
`default_nettype wire

[design/bwfd_div_cell.sv]
`timescale 1ns / 1ps
`default_nettype none
module bwfd_div_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                s_valid,
  output logic                s_ready,
  input  bwfd_pkg::div_item_t s_item,
  output logic                m_valid,
  input  logic                m_ready,
  output bwfd_pkg::div_item_t m_item
);
  import bwfd_pkg::*;

  logic      vld_r;
  div_item_t item_r, item_nxt;
  logic      ge_re, ge_im;

  always_comb begin
    ge_re = DSH_W'(s_item.rem_re) >= s_item.dsh;
    ge_im = DSH_W'(s_item.rem_im) >= s_item.dsh;
    item_nxt        = s_item;
    item_nxt.rem_re = ge_re ? s_item.rem_re - s_item.dsh[NUM_W-1:0] : s_item.rem_re;
    item_nxt.rem_im = ge_im ? s_item.rem_im - s_item.dsh[NUM_W-1:0] : s_item.rem_im;
    item_nxt.q_re   = {s_item.q_re[Q_BITS-2:0], ge_re};
    item_nxt.q_im   = {s_item.q_im[Q_BITS-2:0], ge_im};
    item_nxt.dsh    = s_item.dsh >> 1;
  end

  assign s_ready = !vld_r || m_ready;
  assign m_valid = vld_r;
  assign m_item  = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (s_ready) begin
      vld_r <= s_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_ready) begin
      item_r <= item_nxt;
    end
  end
endmodule
`default_nettype wire

[design/bwfd_sat_out.sv]
`timescale 1ns / 1ps
`default_nettype none
module bwfd_sat_out (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                s_valid,
  output logic                                s_ready,
  input  bwfd_pkg::div_item_t                 s_item,
  output logic                                m_valid,
  input  logic                                m_ready,
  output logic [bwfd_pkg::SAMPLE_WIDTH-1:0]   m_re,
  output logic [bwfd_pkg::SAMPLE_WIDTH-1:0]   m_im
);
  import bwfd_pkg::*;

  localparam logic [Q_BITS-1:0] PMAX = Q_BITS'((1 << (SAMPLE_WIDTH - 1)) - 1);
  localparam logic [SAMPLE_WIDTH-1:0] SMAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam logic [SAMPLE_WIDTH-1:0] SMIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

  function automatic logic [SAMPLE_WIDTH-1:0] sat_q(input logic [Q_BITS-1:0] q,
                                                    input logic neg);
    logic [SAMPLE_WIDTH-1:0] res;
    if (neg) begin
      res = (q > PMAX + Q_BITS'(1)) ? SMIN : -q[SAMPLE_WIDTH-1:0];
    end else begin
      res = (q > PMAX) ? SMAX : q[SAMPLE_WIDTH-1:0];
    end
    return res;
  endfunction

  logic                    vld_r;
  logic [SAMPLE_WIDTH-1:0] re_r, im_r, re_nxt, im_nxt;

  assign re_nxt  = sat_q(s_item.q_re, s_item.neg_re);
  assign im_nxt  = sat_q(s_item.q_im, s_item.neg_im);
  assign s_ready = !vld_r || m_ready;
  assign m_valid = vld_r;
  assign m_re    = re_r;
  assign m_im    = im_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (s_ready) begin
      vld_r <= s_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_ready) begin
      re_r <= re_nxt;
      im_r <= im_nxt;
    end
  end
endmodule
`default_nettype wire

[design/butterworth_freq_domain_filter_core.sv]
// An input transfer reaches its result through 6 setup stages, 18 divider
// cells and 1 output register; it is held up only while the output stalls.
// Throughput: one bin per cycle unless the output stalls; each divider cell
// resolves one quotient bit. Reset (rst_n low, synchronous) empties the
// pipeline and loads order 2, ratio 1.0 and filtering mode.
`timescale 1ns / 1ps
`default_nettype none
module butterworth_freq_domain_filter_core (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  // bin_index[11:0], in_real[27:12], in_imag[43:28], zero fill [47:44]
  input  logic [bwfd_pkg::IN_TDATA_W-1:0]        in_tdata,
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  // out_real[15:0], out_imag[31:16]
  output logic [bwfd_pkg::OUT_TDATA_W-1:0]       out_tdata,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [bwfd_pkg::CFG_INDEX_W-1:0]       cfg_index,
  input  logic [bwfd_pkg::CFG_DATA_W-1:0]        cfg_data
);
  import bwfd_pkg::*;

  logic [ORDER_W-1:0] order_r;
  logic [RATIO_W-1:0] ratio_r;
  logic               resp_r;
  cfg_t               cfg;

  logic      c_valid [0:N_CELLS];
  logic      c_ready [0:N_CELLS];
  div_item_t c_item  [0:N_CELLS];

  logic [SAMPLE_WIDTH-1:0] res_re, res_im;

  assign cfg_ready = 1'b1;
  assign cfg.order = order_r;
  assign cfg.ratio = ratio_r;
  assign cfg.resp  = resp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      order_r <= ORDER_TWO;
      ratio_r <= RATIO_W'(65536);
      resp_r  <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ORDER: order_r <= cfg_data[ORDER_W-1:0];
        REG_RATIO: ratio_r <= cfg_data[RATIO_W-1:0];
        REG_RESP:  resp_r  <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  bwfd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .s_valid   (in_tvalid),
    .s_ready   (in_tready),
    .bin_index (in_tdata[BIN_W-1:0]),
    .in_re     ($signed(in_tdata[BIN_W+SAMPLE_WIDTH-1:BIN_W])),
    .in_im     ($signed(in_tdata[BIN_W+2*SAMPLE_WIDTH-1:BIN_W+SAMPLE_WIDTH])),
    .m_valid   (c_valid[0]),
    .m_ready   (c_ready[0]),
    .m_item    (c_item[0])
  );

  for (genvar g = 0; g < N_CELLS; g++) begin : g_cell
    bwfd_div_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .s_valid (c_valid[g]),
      .s_ready (c_ready[g]),
      .s_item  (c_item[g]),
      .m_valid (c_valid[g+1]),
      .m_ready (c_ready[g+1]),
      .m_item  (c_item[g+1])
    );
  end

  bwfd_sat_out u_out (
    .clk     (clk),
    .rst_n   (rst_n),
    .s_valid (c_valid[N_CELLS]),
    .s_ready (c_ready[N_CELLS]),
    .s_item  (c_item[N_CELLS]),
    .m_valid (out_tvalid),
    .m_ready (out_tready),
    .m_re    (res_re),
    .m_im    (res_im)
  );

  assign out_tdata = {res_im, res_re};
endmodule
`default_nettype wire

[design/bwfd_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
`include "butterworth_freq_domain_filter_core_defines.svh"
module bwfd_checker (
  input wire logic                              clk,
  input wire logic                              rst_n,
  input wire logic                              in_tready,
  input wire logic                              out_tvalid,
  input wire logic                              out_tready,
  input wire logic [bwfd_pkg::OUT_TDATA_W-1:0]  out_tdata,
  input wire logic                              cfg_ready
);
  `BWFD_ASSERT_IMP(a_cfg_ready, 1'b1, cfg_ready, "configuration port not ready")
  `BWFD_ASSERT_IMP(a_empty_ready, !out_tvalid, in_tready, "input stalled with empty output")
  `BWFD_ASSERT_NXT(a_hold_valid, out_tvalid && !out_tready, out_tvalid, "result dropped")
  `BWFD_ASSERT_NXT(a_hold_data, out_tvalid && !out_tready, $stable(out_tdata), "result changed")
  `BWFD_ASSERT_RST(a_reset_empty, $past(!rst_n), !out_tvalid, "result valid after reset")
endmodule

bind butterworth_freq_domain_filter_core bwfd_checker u_bwfd_checker (.*);
`default_nettype wire

[tb/butterworth_freq_domain_filter_core_tb.sv]
`timescale 1ns / 1ps
module butterworth_freq_domain_filter_core_tb;
  import bwfd_pkg::*;

  localparam int LIMIT_CYCLES = 1000000;

  typedef struct {
    logic signed [15:0] re;
    logic signed [15:0] im;
  } bin_pair_t;

  typedef struct {
    bit                 is_cfg;
    logic [1:0]         idx;
    logic [23:0]        cdata;
    logic [11:0]        bin;
    logic signed [15:0] xr;
    logic signed [15:0] xi;
    bit                 typed;
    logic signed [15:0] er;
    logic signed [15:0] ei;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [23:0] cfg_data = '0;

  logic [1:0]  order_q = ORDER_TWO;
  logic [23:0] ratio_q = 24'h010000;
  logic        resp_q = 1'b0;

  bin_pair_t   expected_bins[$];
  int          errors = 0;
  int          checked = 0;
  int          cycles = 0;
  bit          hold_long = 1'b0;
  bit          no_stall = 1'b0;

  butterworth_freq_domain_filter_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic logic [15:0] divide_saturate(longint num, bit [63:0] den, int sh);
    bit [63:0] mag;
    bit [63:0] q;
    mag = (num < 0) ? -num : num;
    if (den == 0) return '0;
    if (sh <= 16) q = (mag << (16 - sh)) / den;
    else q = mag / (den << (sh - 16));
    if (num < 0) begin
      if (q > 64'd32768) q = 64'd32768;
      q = -q;
      return q[15:0];
    end
    if (q > 64'd32767) q = 64'd32767;
    return q[15:0];
  endfunction

  function automatic bin_pair_t filter_bin(logic [11:0] k, logic signed [15:0] in_re,
                                           logic signed [15:0] in_im);
    longint    w, re, im, xr, xi, nr, ni, m;
    bit [63:0] den;
    int        sh;
    bin_pair_t r;
    w = longint'(k) * longint'(ratio_q);
    if (w > 64'hFFFFFF) w = 64'hFFFFFF;
    if (order_q == ORDER_NONE) begin
      re = 65536;
      im = 0;
    end else if (order_q == ORDER_ONE) begin
      re = 65536;
      im = w;
    end else begin
      re = 65536 - ((w * w) >> 16);
      im = (92681 * w) >> 16;
    end
    if (resp_q) begin
      xr = 32768;
      xi = 0;
    end else begin
      xr = in_re;
      xi = in_im;
    end
    m = (re < 0) ? -re : re;
    if (im > m) m = im;
    sh = 0;
    while ((m >> sh) >= (64'd1 << 30)) sh++;
    re = (re < 0) ? -((-re) >> sh) : (re >> sh);
    im = im >> sh;
    den = re * re + im * im;
    nr = xr * re + xi * im;
    ni = xi * re - xr * im;
    r.re = divide_saturate(nr, den, sh);
    r.im = divide_saturate(ni, den, sh);
    return r;
  endfunction

  task automatic write_register(logic [1:0] idx, logic [23:0] value);
    in_tvalid <= 1'b0;
    wait (expected_bins.size() == 0);
    repeat (30) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_ORDER: order_q = value[1:0];
      REG_RATIO: ratio_q = value;
      REG_RESP:  resp_q = value[0];
      default: ;
    endcase
  endtask

  task automatic send_bin(logic [11:0] k, logic signed [15:0] xr, logic signed [15:0] xi,
                          bit typed, bin_pair_t typed_val);
    int gap;
    gap = no_stall ? 0 : $urandom_range(0, 9);
    repeat (gap) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {4'b0, xi, xr, k};
    do @(posedge clk); while (!in_tready);
    expected_bins.push_back(typed ? typed_val : filter_bin(k, xr, xi));
  endtask

  always @(posedge clk) begin
    bin_pair_t e;
    if (rst_n && out_tvalid && out_tready) begin
      checked <= checked + 1;
      if (expected_bins.size() == 0) begin
        $display("%0t: result with nothing expected, actual %h", $time, out_tdata);
        errors <= errors + 1;
      end else begin
        e = expected_bins.pop_front();
        if (out_tdata[15:0] !== e.re) begin
          $display("%0t: out_real expected %0d actual %0d", $time, e.re,
                   $signed(out_tdata[15:0]));
          errors <= errors + 1;
        end
        if (out_tdata[31:16] !== e.im) begin
          $display("%0t: out_imag expected %0d actual %0d", $time, e.im,
                   $signed(out_tdata[31:16]));
          errors <= errors + 1;
        end
      end
    end
  end

  initial begin
    int n;
    wait (rst_n);
    forever begin
      if (hold_long) begin
        out_tready <= 1'b0;
        repeat (300) @(posedge clk);
        hold_long = 1'b0;
      end
      n = no_stall ? 0 : $urandom_range(0, 9);
      if (n > 0) begin
        out_tready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!(out_tvalid && out_tready));
    end
  end

  function automatic logic signed [15:0] rand_sample();
    case ($urandom_range(0, 7))
      0: return 16'sh7FFF;
      1: return -16'sh8000;
      2: return 16'sd0;
      default: return 16'($urandom);
    endcase
  endfunction

  stim_row_t directed[] = '{
    '{0, 0, 0, 12'd0, 16'sh7FFF, -16'sh8000, 1, 16'sh7FFF, -16'sh8000},
    '{0, 0, 0, 12'd0, -16'sh8000, 16'sh7FFF, 1, -16'sh8000, 16'sh7FFF},
    '{0, 0, 0, 12'd1, 16'sd1000, -16'sd1000, 0, 0, 0},
    '{0, 0, 0, 12'd4095, 16'sh7FFF, 16'sh7FFF, 0, 0, 0},
    '{1, REG_ORDER, 24'(ORDER_NONE), 0, 0, 0, 0, 0, 0},
    '{0, 0, 0, 12'd4095, -16'sh8000, -16'sh8000, 1, -16'sh8000, -16'sh8000},
    '{0, 0, 0, 12'd2049, 16'sd1234, -16'sd5, 1, 16'sd1234, -16'sd5},
    '{1, REG_ORDER, 24'(ORDER_ONE), 0, 0, 0, 0, 0, 0},
    '{0, 0, 0, 12'd3, 16'sd20000, -16'sd20000, 0, 0, 0},
    '{1, REG_RATIO, 24'hFFFFFF, 0, 0, 0, 0, 0, 0},
    '{0, 0, 0, 12'd4095, 16'sh7FFF, -16'sh8000, 0, 0, 0},
    '{1, REG_RATIO, 24'h0, 0, 0, 0, 0, 0, 0},
    '{1, REG_RESP, 24'h1, 0, 0, 0, 0, 0, 0},
    '{0, 0, 0, 12'd4095, 16'sd0, 16'sd0, 1, 16'sh7FFF, 16'sd0},
    '{1, REG_RATIO, 24'h010000, 0, 0, 0, 0, 0, 0},
    '{0, 0, 0, 12'd1, 16'sd0, 16'sd0, 0, 0, 0},
    '{1, REG_ORDER, 24'h3, 0, 0, 0, 0, 0, 0},
    '{0, 0, 0, 12'd2, 16'sd77, 16'sd0, 0, 0, 0},
    '{1, 2'd3, 24'h5, 0, 0, 0, 0, 0, 0},
    '{0, 0, 0, 12'd100, 16'sd0, 16'sd0, 0, 0, 0},
    '{1, REG_RESP, 24'h0, 0, 0, 0, 0, 0, 0},
    '{0, 0, 0, 12'd4095, -16'sd1, 16'sd1, 0, 0, 0}
  };

  initial begin
    bin_pair_t tv;
    logic [23:0] ratio_pick;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) begin
      if (directed[i].is_cfg) begin
        write_register(directed[i].idx, directed[i].cdata);
      end else begin
        tv.re = directed[i].er;
        tv.im = directed[i].ei;
        send_bin(directed[i].bin, directed[i].xr, directed[i].xi, directed[i].typed, tv);
      end
    end

    for (int phase = 0; phase < 10; phase++) begin
      case (phase)
        0: ratio_pick = 24'h0;
        1: ratio_pick = 24'hFFFFFF;
        2: ratio_pick = 24'h1;
        3: ratio_pick = 24'h010000;
        default: ratio_pick = 24'($urandom_range(0, 24'h3FFFF));
      endcase
      write_register(REG_ORDER, 24'($urandom_range(0, 3)));
      write_register(REG_RATIO, ratio_pick);
      write_register(REG_RESP, 24'(phase % 2));
      no_stall = (phase == 3);
      for (int i = 0; i < 170; i++) begin
        if (phase == 5 && i == 20) hold_long = 1'b1;
        if (phase == 6 && i == 80) begin
          in_tvalid <= 1'b0;
          wait (expected_bins.size() == 0);
          @(posedge clk);
        end
        send_bin(12'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom),
                 rand_sample(), rand_sample(), 0, tv);
      end
    end
    in_tvalid <= 1'b0;
    no_stall = 1'b0;

    wait (expected_bins.size() == 0);
    repeat (40) @(posedge clk);
    $display("Covered orders zero to three, ratio extremes, response and filter modes,");
    $display("with %0d results checked under random input gaps and output stalls.", checked);
    if (errors == 0 && expected_bins.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
